/* hw/rtl/ute_pkg.sv */
package ute_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_ASCII_RATE    = 3'd0,
    CFG_CJK_RATE      = 3'd1,
    CFG_OTHER_RATE    = 3'd2,
    CFG_MARGIN        = 3'd3,
    CFG_CONTEXT_LIMIT = 3'd4,
    CFG_RESERVED_OUT  = 3'd5
  } cfg_index_e;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef struct packed {
    logic [23:0] ascii_rate;
    logic [23:0] cjk_rate;
    logic [23:0] other_rate;
    logic [15:0] margin;
    logic [31:0] context_limit;
    logic [31:0] reserved_output;
  } cfg_t;

  localparam logic [23:0] ASCII_RATE_RST    = 24'd16384;
  localparam logic [23:0] CJK_RATE_RST      = 24'd65536;
  localparam logic [23:0] OTHER_RATE_RST    = 24'd32768;
  localparam logic [15:0] MARGIN_RST        = 16'd6554;
  localparam logic [31:0] CONTEXT_LIMIT_RST = 32'd8192;
  localparam logic [31:0] RESERVED_OUT_RST  = 32'd0;

  // utf-8 byte patterns
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;

  // cjk code point ranges
  localparam logic [20:0] CJK_EXT_A_LO = 21'h03400;
  localparam logic [20:0] CJK_EXT_A_HI = 21'h04DBF;
  localparam logic [20:0] CJK_BASE_LO  = 21'h04E00;
  localparam logic [20:0] CJK_BASE_HI  = 21'h09FFF;
  localparam logic [20:0] CJK_COMPAT_LO = 21'h0F900;
  localparam logic [20:0] CJK_COMPAT_HI = 21'h0FAFF;
  localparam logic [20:0] CJK_EXT_B_LO = 21'h20000;
  localparam logic [20:0] CJK_EXT_B_HI = 21'h2A6DF;
  localparam logic [20:0] CJK_EXT_C_LO = 21'h2A700;
  localparam logic [20:0] CJK_EXT_C_HI = 21'h2CEAF;
  localparam logic [20:0] CJK_SUPP_LO  = 21'h2F800;
  localparam logic [20:0] CJK_SUPP_HI  = 21'h2FA1F;

  // entries in the message queue
  localparam int unsigned QUEUE_DEPTH = 2;

  function automatic logic is_cjk(input logic [20:0] cp);
    return (cp >= CJK_EXT_A_LO  && cp <= CJK_EXT_A_HI)  ||
           (cp >= CJK_BASE_LO   && cp <= CJK_BASE_HI)   ||
           (cp >= CJK_COMPAT_LO && cp <= CJK_COMPAT_HI) ||
           (cp >= CJK_EXT_B_LO  && cp <= CJK_EXT_B_HI)  ||
           (cp >= CJK_EXT_C_LO  && cp <= CJK_EXT_C_HI)  ||
           (cp >= CJK_SUPP_LO   && cp <= CJK_SUPP_HI);
  endfunction

endpackage

/* hw/rtl/utf8_token_estimator_top.sv */
// throughput: one byte per cycle while the message queue is not full; each message end
// takes the back end through its multiply, margin, rounding and total steps on its one
// shared multiplier, plus an emit step when it closes a request, and a two-entry message
// queue absorbs bursts
// reset: rst_ni is asynchronous, active low; clears decoder, counts, queue, total and
// output valid, and loads the registers with their default rates, margin and limits
module utf8_token_estimator_top #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [ute_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ute_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // byte stream in
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     text_byte_i,
  input  logic                           message_end_i,
  input  logic                           request_end_i,
  // request results out
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [31:0]                    token_total_o,
  output logic                           over_limit_o
);
  import ute_pkg::*;

  localparam int unsigned CW      = COUNT_WIDTH;
  localparam int unsigned ENTRY_W = 3 * CW + 1;

  cfg_t cfg_q, cfg_d;

  // register file; write it only while the block is idle, which the block itself does not enforce
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_ASCII_RATE:    cfg_d.ascii_rate      = cfg_data_i[23:0];
        CFG_CJK_RATE:      cfg_d.cjk_rate        = cfg_data_i[23:0];
        CFG_OTHER_RATE:    cfg_d.other_rate      = cfg_data_i[23:0];
        CFG_MARGIN:        cfg_d.margin          = cfg_data_i[15:0];
        CFG_CONTEXT_LIMIT: cfg_d.context_limit   = cfg_data_i;
        CFG_RESERVED_OUT:  cfg_d.reserved_output = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ascii_rate      <= ASCII_RATE_RST;
      cfg_q.cjk_rate        <= CJK_RATE_RST;
      cfg_q.other_rate      <= OTHER_RATE_RST;
      cfg_q.margin          <= MARGIN_RST;
      cfg_q.context_limit   <= CONTEXT_LIMIT_RST;
      cfg_q.reserved_output <= RESERVED_OUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front to queue
  logic               push;
  logic               queue_full;
  logic [CW-1:0]      push_ascii, push_cjk, push_other;
  logic               push_last;
  logic [ENTRY_W-1:0] push_entry;

  // queue to back
  logic               queue_empty;
  logic               pop;
  logic [ENTRY_W-1:0] head_entry;

  // decoder and per-message class counters, one byte per transfer
  ute_front #(
    .COUNT_WIDTH(CW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .text_byte_i   (text_byte_i),
    .message_end_i (message_end_i),
    .request_end_i (request_end_i),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .push_ascii_o  (push_ascii),
    .push_cjk_o    (push_cjk),
    .push_other_o  (push_other),
    .push_last_o   (push_last)
  );

  // entry layout: request-end flag, then ascii, cjk and other counts
  assign push_entry = {push_last, push_ascii, push_cjk, push_other};

  // finished message counts wait here for the estimator
  ute_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (queue_full),
    .pop_i   (pop),
    .empty_o (queue_empty),
    .data_o  (head_entry)
  );

  // estimate, margin, rounding, request total and budget check
  ute_back #(
    .COUNT_WIDTH(CW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .entry_valid_i (~queue_empty),
    .entry_ascii_i (head_entry[3*CW-1:2*CW]),
    .entry_cjk_i   (head_entry[2*CW-1:CW]),
    .entry_other_i (head_entry[CW-1:0]),
    .entry_last_i  (head_entry[3*CW]),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .token_total_o (token_total_o),
    .over_limit_o  (over_limit_o)
  );

endmodule

/* hw/rtl/ute_front.sv */
module ute_front #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             text_byte_i,
  input  logic                   message_end_i,
  input  logic                   request_end_i,
  input  logic                   queue_full_i,
  output logic                   push_o,
  output logic [COUNT_WIDTH-1:0] push_ascii_o,
  output logic [COUNT_WIDTH-1:0] push_cjk_o,
  output logic [COUNT_WIDTH-1:0] push_other_o,
  output logic                   push_last_o
);
  import ute_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;

  logic [1:0]    needed_q, needed_d, needed_n;
  logic [1:0]    seen_q, seen_d, seen_n, seen_inc;
  logic [20:0]   point_q, point_d, point_n, pt_ext;
  logic [CW-1:0] ascii_q, ascii_d, ascii_sat;
  logic [CW-1:0] cjk_q, cjk_d, cjk_sat;
  logic [CW-1:0] other_q, other_d, other_sat;
  logic [CW:0]   ascii_sum, cjk_sum, other_sum;
  logic          accept, is_cont, closing, inc_a, inc_c;
  logic [2:0]    inc_o;

  assign accept     = in_valid_i & ~queue_full_i;
  assign in_stall_o = queue_full_i;
  assign is_cont    = (text_byte_i & CONT_MASK) == CONT_CODE;
  assign closing    = message_end_i | request_end_i;
  assign pt_ext     = {point_q[14:0], text_byte_i[5:0]};
  assign seen_inc   = seen_q + 2'd1;

  // per-byte decode: class increments and next decoder state
  always_comb begin
    inc_a    = 1'b0;
    inc_c    = 1'b0;
    inc_o    = 3'd0;
    needed_n = needed_q;
    seen_n   = seen_q;
    point_n  = point_q;
    if (needed_q != 2'd0 && is_cont) begin
      if (seen_inc == needed_q) begin
        if (pt_ext[20:7] == 14'd0) begin
          inc_a = 1'b1;
        end else if (is_cjk(pt_ext)) begin
          inc_c = 1'b1;
        end else begin
          inc_o = 3'd1;
        end
        needed_n = 2'd0;
        seen_n   = 2'd0;
        point_n  = 21'd0;
      end else begin
        seen_n  = seen_inc;
        point_n = pt_ext;
      end
    end else begin
      // broken sequence: lead plus continuations so far
      if (needed_q != 2'd0) begin
        inc_o = 3'd1 + {1'b0, seen_q};
      end
      needed_n = 2'd0;
      seen_n   = 2'd0;
      point_n  = 21'd0;
      if (!text_byte_i[7]) begin
        inc_a = 1'b1;
      end else if ((text_byte_i & LEAD2_MASK) == LEAD2_CODE) begin
        needed_n = 2'd1;
        point_n  = {16'd0, text_byte_i[4:0]};
      end else if ((text_byte_i & LEAD3_MASK) == LEAD3_CODE) begin
        needed_n = 2'd2;
        point_n  = {17'd0, text_byte_i[3:0]};
      end else if ((text_byte_i & LEAD4_MASK) == LEAD4_CODE) begin
        needed_n = 2'd3;
        point_n  = {18'd0, text_byte_i[2:0]};
      end else begin
        inc_o = inc_o + 3'd1;
      end
    end
    // sequence cut by message or request end
    if (closing && needed_n != 2'd0) begin
      inc_o = inc_o + 3'd1 + {1'b0, seen_n};
    end
  end

  assign ascii_sum = {1'b0, ascii_q} + (CW+1)'(inc_a);
  assign cjk_sum   = {1'b0, cjk_q} + (CW+1)'(inc_c);
  assign other_sum = {1'b0, other_q} + (CW+1)'(inc_o);
  assign ascii_sat = ascii_sum[CW] ? '1 : ascii_sum[CW-1:0];
  assign cjk_sat   = cjk_sum[CW] ? '1 : cjk_sum[CW-1:0];
  assign other_sat = other_sum[CW] ? '1 : other_sum[CW-1:0];

  always_comb begin
    needed_d = needed_q;
    seen_d   = seen_q;
    point_d  = point_q;
    ascii_d  = ascii_q;
    cjk_d    = cjk_q;
    other_d  = other_q;
    if (accept) begin
      if (closing) begin
        needed_d = 2'd0;
        seen_d   = 2'd0;
        point_d  = 21'd0;
        ascii_d  = '0;
        cjk_d    = '0;
        other_d  = '0;
      end else begin
        needed_d = needed_n;
        seen_d   = seen_n;
        point_d  = point_n;
        ascii_d  = ascii_sat;
        cjk_d    = cjk_sat;
        other_d  = other_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needed_q <= 2'd0;
      seen_q   <= 2'd0;
      point_q  <= 21'd0;
      ascii_q  <= '0;
      cjk_q    <= '0;
      other_q  <= '0;
    end else begin
      needed_q <= needed_d;
      seen_q   <= seen_d;
      point_q  <= point_d;
      ascii_q  <= ascii_d;
      cjk_q    <= cjk_d;
      other_q  <= other_d;
    end
  end

  assign push_o       = accept & closing;
  assign push_ascii_o = ascii_sat;
  assign push_cjk_o   = cjk_sat;
  assign push_other_o = other_sat;
  assign push_last_o  = request_end_i;

endmodule

/* hw/rtl/ute_queue.sv */
module ute_queue #(
  parameter int unsigned WIDTH = 73
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  import ute_pkg::*;

  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

  logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  assign full_o  = fill_q == FULL_FILL;
  assign empty_o = fill_q == '0;
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + FILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FILL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

/* hw/rtl/ute_back.sv */
module ute_back #(
  parameter int unsigned COUNT_WIDTH = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ute_pkg::cfg_t          cfg_i,
  input  logic                   entry_valid_i,
  input  logic [COUNT_WIDTH-1:0] entry_ascii_i,
  input  logic [COUNT_WIDTH-1:0] entry_cjk_i,
  input  logic [COUNT_WIDTH-1:0] entry_other_i,
  input  logic                   entry_last_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [31:0]            token_total_o,
  output logic                   over_limit_o
);
  import ute_pkg::*;

  localparam int unsigned CW     = COUNT_WIDTH;
  localparam int unsigned RAW_W  = CW + 26;      // sum of three CW x 24 products
  localparam int unsigned PROD_W = RAW_W + 17;   // raw times (1 + margin) in Q32

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_C,
    ST_MUL_O,
    ST_MARG_LO,
    ST_MARG_HI,
    ST_ROUND,
    ST_TOTAL,
    ST_EMIT
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     a_q, a_d, c_q, c_d, o_q, o_d;
  logic              last_q, last_d;
  logic [RAW_W-1:0]  raw_q, raw_d;
  logic [PROD_W-1:0] val_q, val_d;
  logic [31:0]       est_q, est_d, total_q, total_d, token_total_q, token_total_d;
  logic              out_valid_q, out_valid_d, over_limit_q, over_limit_d;
  logic [31:0]       mul_a;
  logic [23:0]       mul_b;
  logic [55:0]       mul_p;
  logic [63:0]       whole;
  logic [32:0]       total_sum, need_sum;

  // one shared multiplier, operands picked by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MUL_A: begin
        mul_a = 32'(a_q);
        mul_b = cfg_i.ascii_rate;
      end
      ST_MUL_C: begin
        mul_a = 32'(c_q);
        mul_b = cfg_i.cjk_rate;
      end
      ST_MUL_O: begin
        mul_a = 32'(o_q);
        mul_b = cfg_i.other_rate;
      end
      ST_MARG_LO: begin
        mul_a = raw_q[31:0];
        mul_b = {8'd0, cfg_i.margin};
      end
      ST_MARG_HI: begin
        mul_a = 32'(raw_q >> 32);
        mul_b = {8'd0, cfg_i.margin};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p     = {24'd0, mul_a} * {32'd0, mul_b};
  assign whole     = 64'(val_q >> 32) + ((val_q[31:0] != 32'd0) ? 64'd1 : 64'd0);
  assign total_sum = {1'b0, total_q} + {1'b0, est_q};
  assign need_sum  = {1'b0, total_q} + {1'b0, cfg_i.reserved_output};
  assign pop_o     = (state_q == ST_IDLE) & entry_valid_i;

  always_comb begin
    state_d       = state_q;
    a_d           = a_q;
    c_d           = c_q;
    o_d           = o_q;
    last_d        = last_q;
    raw_d         = raw_q;
    val_d         = val_q;
    est_d         = est_q;
    total_d       = total_q;
    token_total_d = token_total_q;
    over_limit_d  = over_limit_q;
    out_valid_d   = out_valid_q & out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (entry_valid_i) begin
          a_d     = entry_ascii_i;
          c_d     = entry_cjk_i;
          o_d     = entry_other_i;
          last_d  = entry_last_i;
          state_d = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        raw_d   = RAW_W'(mul_p);
        state_d = ST_MUL_C;
      end
      ST_MUL_C: begin
        raw_d   = raw_q + RAW_W'(mul_p);
        state_d = ST_MUL_O;
      end
      ST_MUL_O: begin
        raw_d   = raw_q + RAW_W'(mul_p);
        state_d = ST_MARG_LO;
      end
      ST_MARG_LO: begin
        val_d   = (PROD_W'(raw_q) << 16) + PROD_W'(mul_p);
        state_d = ST_MARG_HI;
      end
      ST_MARG_HI: begin
        val_d   = val_q + (PROD_W'(mul_p) << 32);
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        est_d   = (whole > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : whole[31:0];
        state_d = ST_TOTAL;
      end
      ST_TOTAL: begin
        total_d = total_sum[32] ? 32'hFFFF_FFFF : total_sum[31:0];
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          token_total_d = total_q;
          over_limit_d  = need_sum > {1'b0, cfg_i.context_limit};
          out_valid_d   = 1'b1;
          total_d       = 32'd0;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      a_q           <= '0;
      c_q           <= '0;
      o_q           <= '0;
      last_q        <= 1'b0;
      raw_q         <= '0;
      val_q         <= '0;
      est_q         <= 32'd0;
      total_q       <= 32'd0;
      token_total_q <= 32'd0;
      over_limit_q  <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      a_q           <= a_d;
      c_q           <= c_d;
      o_q           <= o_d;
      last_q        <= last_d;
      raw_q         <= raw_d;
      val_q         <= val_d;
      est_q         <= est_d;
      total_q       <= total_d;
      token_total_q <= token_total_d;
      over_limit_q  <= over_limit_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign token_total_o = token_total_q;
  assign over_limit_o  = over_limit_q;

endmodule

/* tb/utf8_token_estimator_top_tb.sv */
`timescale 1ns / 1ps

module utf8_token_estimator_top_tb;
  import ute_pkg::*;

  localparam int unsigned COUNT_W = 24;
  // back end steps through each message, plus an emit step per request, and holds two queued
  localparam int unsigned BACKEND_SLACK = 40;
  localparam int unsigned PHASE_BYTES = 115;
  localparam int unsigned RUN_LIMIT_NS = 400000;

  // one byte of message text with its framing flags
  typedef struct packed {
    logic [7:0] data;
    logic       msg_end;
    logic       req_end;
  } text_item_t;

  // what one request end should produce
  typedef struct packed {
    logic [31:0] total;
    logic        over;
  } request_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                   cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] text_byte_i = '0;
  logic       message_end_i = 1'b0;
  logic       request_end_i = 1'b0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] token_total_o;
  logic        over_limit_o;

  utf8_token_estimator_top #(
    .COUNT_WIDTH(COUNT_W)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .text_byte_i,
    .message_end_i,
    .request_end_i,
    .out_valid_o,
    .out_stall_i,
    .token_total_o,
    .over_limit_o
  );

  // bytes waiting for transfer, head is the one on the port while valid is high
  text_item_t      byte_q[$];
  // request results still owed by the block, oldest first
  request_result_t request_totals_q[$];
  // bytes of the message being built
  logic [7:0]      msg_buf[$];

  int send_idle_pct = 27;
  int recv_stall_pct = 46;
  int errors = 0;
  int pushed_count = 0;

  // shadow of the configuration registers
  logic [23:0] rate_ascii = ASCII_RATE_RST;
  logic [23:0] rate_cjk = CJK_RATE_RST;
  logic [23:0] rate_other = OTHER_RATE_RST;
  logic [15:0] margin_q16 = MARGIN_RST;
  logic [31:0] ctx_limit = CONTEXT_LIMIT_RST;
  logic [31:0] out_reserve = RESERVED_OUT_RST;

  // shadow of the decoder, the per-message counts and the request total
  logic [1:0]         seq_len = '0;
  logic [1:0]         seq_got = '0;
  logic [20:0]        code_pt = '0;
  logic [COUNT_W-1:0] n_ascii = '0;
  logic [COUNT_W-1:0] n_cjk = '0;
  logic [COUNT_W-1:0] n_other = '0;
  logic [31:0]        run_total = '0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // token estimate prediction
  // ---------------------------------------------------------------------------

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c,
                                                 input int unsigned n);
    logic [COUNT_W:0] s;
    s = {1'b0, c} + (COUNT_W+1)'(n);
    return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
  endfunction

  // ideograph blocks: ext a, unified, compatibility, ext b, ext c, supplement
  function automatic void han_range(input int r, output logic [20:0] lo,
                                    output logic [20:0] hi);
    case (r)
      0: begin lo = 21'h03400; hi = 21'h04DBF; end
      1: begin lo = 21'h04E00; hi = 21'h09FFF; end
      2: begin lo = 21'h0F900; hi = 21'h0FAFF; end
      3: begin lo = 21'h20000; hi = 21'h2A6DF; end
      4: begin lo = 21'h2A700; hi = 21'h2CEAF; end
      default: begin lo = 21'h2F800; hi = 21'h2FA1F; end
    endcase
  endfunction

  function automatic bit is_han(input logic [20:0] cp);
    logic [20:0] lo, hi;
    bit          hit;
    hit = 1'b0;
    for (int r = 0; r < 6; r++) begin
      han_range(r, lo, hi);
      if (cp >= lo && cp <= hi) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic tally_point(input logic [20:0] cp);
    if (cp <= 21'h7F) n_ascii = sat_inc(n_ascii, 1);
    else if (is_han(cp)) n_cjk = sat_inc(n_cjk, 1);
    else n_other = sat_inc(n_other, 1);
  endtask

  // an unfinished sequence costs one other char per byte seen
  task automatic drop_open_seq();
    if (seq_len != 2'd0) n_other = sat_inc(n_other, 32'(seq_got) + 1);
    seq_len = '0;
    seq_got = '0;
    code_pt = '0;
  endtask

  task automatic start_char(input logic [7:0] b);
    seq_got = '0;
    if (!b[7]) begin
      n_ascii = sat_inc(n_ascii, 1);
    end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
      seq_len = 2'd1;
      code_pt = {16'd0, b[4:0]};
    end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
      seq_len = 2'd2;
      code_pt = {17'd0, b[3:0]};
    end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
      seq_len = 2'd3;
      code_pt = {18'd0, b[2:0]};
    end else begin
      n_other = sat_inc(n_other, 1);
    end
  endtask

  // ceil(raw * (1 + margin)) taken from the exact q32 product, clipped to 32 bits
  function automatic logic [31:0] message_tokens();
    logic [63:0] raw;
    logic [79:0] prod;
    logic [47:0] whole;
    raw = 64'(n_ascii) * 64'(rate_ascii) + 64'(n_cjk) * 64'(rate_cjk) +
          64'(n_other) * 64'(rate_other);
    prod = 80'(raw) * (80'h10000 + 80'(margin_q16));
    whole = prod[79:32] + 48'(prod[31:0] != 32'd0);
    return (whole > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : whole[31:0];
  endfunction

  task automatic count_byte(input logic [7:0] b, input logic me, input logic re);
    logic [32:0]     sum;
    logic [32:0]     need;
    request_result_t res;
    if (seq_len != 2'd0 && (b & CONT_MASK) == CONT_CODE) begin
      code_pt = {code_pt[14:0], b[5:0]};
      seq_got = seq_got + 2'd1;
      if (seq_got == seq_len) begin
        tally_point(code_pt);
        seq_len = '0;
        seq_got = '0;
        code_pt = '0;
      end
    end else begin
      drop_open_seq();
      start_char(b);
    end

    if (me || re) begin
      drop_open_seq();
      sum = {1'b0, run_total} + {1'b0, message_tokens()};
      run_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      n_ascii = '0;
      n_cjk = '0;
      n_other = '0;
    end

    if (re) begin
      // 33-bit compare so a huge reserve cannot wrap
      need = {1'b0, run_total} + {1'b0, out_reserve};
      res.total = run_total;
      res.over = (need > {1'b0, ctx_limit});
      request_totals_q.push_back(res);
      run_total = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: predicts on every transfer, then offers the next byte
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : feed
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        count_byte(text_byte_i, message_end_i, request_end_i);
        byte_q.delete(0);
      end
      // a stalled byte stays put, otherwise pick the next one or idle
      if (!(in_valid_i && in_stall_o)) begin
        if (byte_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          text_byte_i <= byte_q[0].data;
          message_end_i <= byte_q[0].msg_end;
          request_end_i <= byte_q[0].req_end;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor with random back pressure
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : watch
    request_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (request_totals_q.size() == 0) begin
        $display("%0t: result with no request pending, token_total %0d over_limit %0b",
                 $time, token_total_o, over_limit_o);
        errors++;
      end else begin
        want = request_totals_q.pop_front();
        if (token_total_o !== want.total) begin
          $display("%0t: token_total mismatch, expected %0d, got %0d",
                   $time, want.total, token_total_o);
          errors++;
        end
        if (over_limit_o !== want.over) begin
          $display("%0t: over_limit mismatch, expected %0b, got %0b",
                   $time, want.over, over_limit_o);
          errors++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] b, input logic me, input logic re);
    text_item_t it;
    it.data = b;
    it.msg_end = me;
    it.req_end = re;
    byte_q.push_back(it);
    pushed_count++;
  endtask

  // flags go on the last byte of the message
  task automatic flush_message(input logic me, input logic re);
    int n;
    n = msg_buf.size();
    for (int i = 0; i < n; i++) begin
      push_byte(msg_buf[i], (i == n - 1) && me, (i == n - 1) && re);
    end
    msg_buf.delete();
  endtask

  function automatic logic [20:0] rand_point(input int len);
    case (len)
      2: return 21'($urandom_range(0, 'h7FF));
      3: return 21'($urandom_range(0, 'hFFFF));
      default: return 21'($urandom_range(0, 'h1FFFFF));
    endcase
  endfunction

  // one character, mostly well formed, sometimes noise or a cut sequence
  task automatic add_char();
    int          kind, len, n;
    logic [20:0] cp, lo, hi;
    logic [7:0]  enc[4];
    kind = $urandom_range(0, 99);
    cp = '0;
    len = 1;
    n = 0;
    if (kind < 35) begin
      cp = 21'($urandom_range(0, 'h7F));
    end else if (kind < 50) begin
      len = 2;
      cp = rand_point(2);
    end else if (kind < 70) begin
      // ideographs, with the block edges hit often
      han_range($urandom_range(0, 5), lo, hi);
      case ($urandom_range(0, 3))
        0: cp = lo - 21'd1;
        1: cp = hi + 21'd1;
        default: cp = 21'($urandom_range(lo, hi));
      endcase
      len = (cp > 21'hFFFF) ? 4 : 3;
    end else if (kind < 78) begin
      len = $urandom_range(3, 4);
      cp = rand_point(len);
    end else if (kind < 84) begin
      msg_buf.push_back(8'($urandom_range('h80, 'hBF)));
      return;
    end else if (kind < 88) begin
      msg_buf.push_back(8'($urandom_range('hF8, 'hFF)));
      return;
    end else if (kind < 94) begin
      msg_buf.push_back(8'($urandom_range(0, 255)));
      return;
    end else begin
      // lead plus too few continuation bytes
      len = $urandom_range(2, 4);
      cp = rand_point(len);
      n = $urandom_range(1, len - 1);
    end

    case (len)
      1: enc[0] = {1'b0, cp[6:0]};
      2: enc[0] = {3'b110, cp[10:6]};
      3: enc[0] = {4'b1110, cp[15:12]};
      default: enc[0] = {5'b11110, cp[20:18]};
    endcase
    for (int i = 1; i < len; i++) enc[i] = {2'b10, cp[6 * (len - 1 - i) +: 6]};
    if (n == 0) n = len;
    for (int i = 0; i < n; i++) msg_buf.push_back(enc[i]);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (byte_q.size() != 0 || in_valid_i || request_totals_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // idle plus time for a message end that owes no result to leave the back end
  task automatic settle();
    wait_idle();
    repeat (BACKEND_SLACK) @(negedge clk_i);
  endtask

  // 1 to 3 messages, or 2 with hold_mid, where the sender waits out the block after the first
  task automatic gen_request(input bit hold_mid);
    int n_msg;
    bit last;
    n_msg = hold_mid ? 2 : $urandom_range(1, 3);
    for (int k = 0; k < n_msg; k++) begin
      last = (k == n_msg - 1);
      repeat ($urandom_range(1, 5)) add_char();
      flush_message(last ? 1'($urandom_range(0, 1)) : 1'b1, last);
      if (hold_mid && k == 0) wait_idle();
    end
  endtask

  task automatic gen_phase();
    int base;
    base = pushed_count;
    while (pushed_count - base < PHASE_BYTES) gen_request(1'b0);
  endtask

  task automatic cfg_write(input cfg_index_e idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ASCII_RATE:    rate_ascii = val[23:0];
      CFG_CJK_RATE:      rate_cjk = val[23:0];
      CFG_OTHER_RATE:    rate_other = val[23:0];
      CFG_MARGIN:        margin_q16 = val[15:0];
      CFG_CONTEXT_LIMIT: ctx_limit = val;
      CFG_RESERVED_OUT:  out_reserve = val;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed bytes under the reset configuration
    push_byte(8'h41, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b0);
    push_byte(8'hC2, 1'b0, 1'b0);   // first non-ascii point, other
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'hC0, 1'b0, 1'b0);   // overlong nul counts as ascii
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'hE4, 1'b0, 1'b0);   // first unified ideograph
    push_byte(8'hB8, 1'b0, 1'b0);
    push_byte(8'h80, 1'b1, 1'b0);
    push_byte(8'hE3, 1'b0, 1'b0);   // ext a start
    push_byte(8'h90, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'hF0, 1'b0, 1'b0);   // ext b start
    push_byte(8'hA0, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'h80, 1'b1, 1'b1);
    push_byte(8'hF7, 1'b0, 1'b0);   // largest 4-byte point
    push_byte(8'hBF, 1'b0, 1'b0);
    push_byte(8'hBF, 1'b0, 1'b0);
    push_byte(8'hBF, 1'b0, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);   // stray continuation
    push_byte(8'hFF, 1'b0, 1'b0);   // never valid in utf-8
    push_byte(8'hE4, 1'b0, 1'b0);   // broken by an ascii byte
    push_byte(8'hB8, 1'b0, 1'b0);
    push_byte(8'h41, 1'b0, 1'b0);
    push_byte(8'hF0, 1'b0, 1'b0);   // sequence cut by message end
    push_byte(8'h90, 1'b1, 1'b0);
    push_byte(8'hC3, 1'b0, 1'b1);   // lead cut by request end alone

    // extremes: max ascii and other rates and margin, zero cjk rate, limit and reserve, sender light idle
    settle();
    cfg_write(CFG_ASCII_RATE, 32'h00FF_FFFF);
    cfg_write(CFG_CJK_RATE, 32'h0000_0000);
    cfg_write(CFG_OTHER_RATE, 32'h00FF_FFFF);
    cfg_write(CFG_MARGIN, 32'h0000_FFFF);
    cfg_write(CFG_CONTEXT_LIMIT, 32'h0000_0000);
    cfg_write(CFG_RESERVED_OUT, 32'h0000_0000);
    @(negedge clk_i);
    gen_phase();

    // opposite extremes, reserve at max so the compare needs its carry bit
    settle();
    send_idle_pct = 46;
    recv_stall_pct = 27;
    cfg_write(CFG_ASCII_RATE, 32'h0000_0000);
    cfg_write(CFG_CJK_RATE, 32'h00FF_FFFF);
    cfg_write(CFG_OTHER_RATE, 32'h0000_0001);
    cfg_write(CFG_MARGIN, 32'h0000_0000);
    cfg_write(CFG_CONTEXT_LIMIT, 32'hFFFF_FFFF);
    cfg_write(CFG_RESERVED_OUT, 32'hFFFF_FFFF);
    @(negedge clk_i);
    gen_phase();

    // random moderate settings so over_limit goes both ways, no idling at all
    settle();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cfg_write(CFG_ASCII_RATE, $urandom_range(0, 'h3FFFF));
    cfg_write(CFG_CJK_RATE, $urandom_range(0, 'h3FFFF));
    cfg_write(CFG_OTHER_RATE, $urandom_range(0, 'h3FFFF));
    cfg_write(CFG_MARGIN, $urandom_range(0, 'hFFFF));
    cfg_write(CFG_CONTEXT_LIMIT, $urandom_range(0, 40));
    cfg_write(CFG_RESERVED_OUT, $urandom_range(0, 20));
    @(negedge clk_i);
    // sender drains the block in the middle of a request
    gen_request(1'b1);
    gen_phase();

    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* utf8_token_estimator_top.f */
hw/rtl/ute_pkg.sv
hw/rtl/ute_front.sv
hw/rtl/ute_queue.sv
hw/rtl/ute_back.sv
hw/rtl/utf8_token_estimator_top.sv
tb/utf8_token_estimator_top_tb.sv
